/* hw/rtl/ripd_pkg.sv */
// ripd_pkg: shared types, widths and codes for the rate integrating pointer delta block.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package ripd_pkg;

    // Field widths
    localparam int ACC_FRAC_BITS = 16;
    localparam int ADC_BITS      = 12;
    localparam int US_W          = 20;
    localparam int RATE_W        = 16;
    localparam int GAIN_W        = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int MOVE_X_W      = 9;
    localparam int MOVE_Y_W      = 8;

    // Centred sample: gyro rate or stick minus rest value
    localparam int S_W = (ADC_BITS + 1 > RATE_W) ? ADC_BITS + 1 : RATE_W;

    // Datapath widths
    localparam int GAIN_SHIFT = 32;
    localparam int M_W        = S_W + US_W + 1;     // sample times microseconds
    localparam int LO_W       = M_W / 2;            // low slice of that product
    localparam int HI_W       = M_W - LO_W;         // signed high slice
    localparam int PL_W       = LO_W + GAIN_W;      // low partial product
    localparam int PH_W       = HI_W + GAIN_W + 1;  // high partial product
    localparam int P_W        = M_W + GAIN_W;       // full product
    localparam int I_W        = P_W - GAIN_SHIFT;   // increment after the shift
    localparam int ACC_W      = 48;
    localparam int IP_W       = ACC_W - ACC_FRAC_BITS;

    // Command queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Register reset values
    localparam logic [GAIN_W-1:0]   GYRO_GAIN_RST    = GAIN_W'(34359738);
    localparam logic [GAIN_W-1:0]   JOY_GAIN_RST     = GAIN_W'(93824992);
    localparam logic [ADC_BITS-1:0] JOY_CENTER_X_RST = ADC_BITS'(1958);
    localparam logic [ADC_BITS-1:0] JOY_CENTER_Y_RST = ADC_BITS'(2019);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GYRO_GAIN    = 2'd0,
        REG_JOY_GAIN     = 2'd1,
        REG_JOY_CENTER_X = 2'd2,
        REG_JOY_CENTER_Y = 2'd3
    } reg_idx_t;

    // Input item modes
    typedef enum logic [1:0] {
        MODE_GYRO   = 2'd0,
        MODE_JOY    = 2'd1,
        MODE_REPORT = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    // Classified commands
    typedef enum logic {
        OP_ACCUM  = 1'b0,
        OP_REPORT = 1'b1
    } op_t;

    typedef struct packed {
        op_t                    op;
        logic signed [S_W-1:0]  s_pitch;
        logic signed [S_W-1:0]  s_yaw;
        logic [US_W-1:0]        us;
        logic [GAIN_W-1:0]      gain;
    } q_entry_t;

    // Back end sequencer
    typedef enum logic [2:0] {
        B_IDLE,
        B_PP,
        B_SUM,
        B_ACC,
        B_REP
    } bk_state_t;

    typedef struct packed {
        logic pop;
        logic load_m;
        logic load_ip;
        logic load_pp;
        logic load_incr;
        logic load_acc;
        logic load_rep;
    } bk_ctrl_t;

endpackage

/* hw/rtl/ripd_front.sv */
// ripd_front: configuration registers and input classification.
// Depends on ripd_pkg; feeds classified commands into ripd_queue.
`timescale 1ns / 1ps

module ripd_front
    import ripd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    // input items
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  mode,
    input  logic [US_W-1:0]             elapsed_us,
    input  logic signed [RATE_W-1:0]    rate_pitch,
    input  logic signed [RATE_W-1:0]    rate_yaw,
    input  logic [ADC_BITS-1:0]         stick_x,
    input  logic [ADC_BITS-1:0]         stick_y,
    // command queue
    input  logic                        q_full,
    output logic                        q_push,
    output q_entry_t                    q_wdata
);

    logic [GAIN_W-1:0]   gyro_gain_reg;
    logic [GAIN_W-1:0]   joy_gain_reg;
    logic [ADC_BITS-1:0] joy_center_x_reg;
    logic [ADC_BITS-1:0] joy_center_y_reg;
    logic signed [ADC_BITS:0] cx;
    logic signed [ADC_BITS:0] cy;
    logic                in_xfer;
    mode_t               mode_c;

    assign cfg_ready = 1'b1;

    // Take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_gain_reg    <= GYRO_GAIN_RST;
            joy_gain_reg     <= JOY_GAIN_RST;
            joy_center_x_reg <= JOY_CENTER_X_RST;
            joy_center_y_reg <= JOY_CENTER_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_idx_t'(cfg_index))
                REG_GYRO_GAIN:    gyro_gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_JOY_GAIN:     joy_gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_JOY_CENTER_X: joy_center_x_reg <= cfg_data[ADC_BITS-1:0];
                REG_JOY_CENTER_Y: joy_center_y_reg <= cfg_data[ADC_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Hold the input while the queue is full
    assign in_stall = q_full;
    assign in_xfer  = in_valid && !in_stall;
    assign mode_c   = mode_t'(mode);

    // Centre the stick readings
    assign cx = $signed({1'b0, stick_x}) - $signed({1'b0, joy_center_x_reg});
    assign cy = $signed({1'b0, stick_y}) - $signed({1'b0, joy_center_y_reg});

    // Classify the transfer; drop the unused mode
    always_comb
    begin
        q_push          = 1'b0;
        q_wdata.op      = OP_ACCUM;
        q_wdata.s_pitch = S_W'(rate_pitch);
        q_wdata.s_yaw   = S_W'(rate_yaw);
        q_wdata.us      = elapsed_us;
        q_wdata.gain    = gyro_gain_reg;
        case (mode_c)
            MODE_GYRO:
            begin
                q_push = in_xfer;
            end
            MODE_JOY:
            begin
                q_push          = in_xfer;
                q_wdata.s_pitch = S_W'(cx);
                q_wdata.s_yaw   = S_W'(cy);
                q_wdata.gain    = joy_gain_reg;
            end
            MODE_REPORT:
            begin
                q_push     = in_xfer;
                q_wdata.op = OP_REPORT;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

endmodule

/* hw/rtl/ripd_queue.sv */
// ripd_queue: short command queue between the front and back ends.
// Depends on ripd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module ripd_queue
    import ripd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t wdata,
    output logic     full,
    input  logic     pop,
    output q_entry_t rdata,
    output logic     empty
);

    q_entry_t             q_mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = q_mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* hw/rtl/ripd_back.sv */
// ripd_back: sequencer that scales samples into the two accumulators and
// emits pointer deltas on report commands. Depends on ripd_pkg.
`timescale 1ns / 1ps

module ripd_back
    import ripd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    // command queue
    input  q_entry_t                    q_rdata,
    input  logic                        q_empty,
    output logic                        q_pop,
    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [MOVE_X_W-1:0]  move_x,
    output logic signed [MOVE_Y_W-1:0]  move_y
);

    localparam int NUM_AXES = 2;   // lane 0 pitch, lane 1 yaw
    localparam logic signed [IP_W-1:0]  IP_MAX  = IP_W'(127);
    localparam logic signed [IP_W-1:0]  IP_MIN  = -IP_W'(128);
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    bk_state_t state_reg;
    bk_state_t state_next;
    bk_ctrl_t  ctrl;

    logic signed [S_W-1:0]      s_lane [NUM_AXES];
    logic signed [M_W-1:0]      m_reg [NUM_AXES];
    logic [GAIN_W-1:0]          gain_reg;
    logic [PL_W-1:0]            pp_lo_reg [NUM_AXES];
    logic signed [PH_W-1:0]     pp_hi_reg [NUM_AXES];
    logic signed [I_W-1:0]      incr_reg [NUM_AXES];
    logic signed [ACC_W-1:0]    acc_reg [NUM_AXES];
    logic signed [MOVE_Y_W-1:0] ip_reg [NUM_AXES];
    logic signed [MOVE_Y_W-1:0] ip_next [NUM_AXES];
    logic signed [ACC_W-1:0]    acc_next [NUM_AXES];
    logic [PL_W-1:0]            pp_lo_next [NUM_AXES];
    logic signed [PH_W-1:0]     pp_hi_next [NUM_AXES];
    logic signed [I_W-1:0]      incr_next [NUM_AXES];
    logic signed [M_W-1:0]      m_next [NUM_AXES];
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic signed [MOVE_X_W-1:0] move_x_reg;
    logic signed [MOVE_Y_W-1:0] move_y_reg;
    logic                       slot_free;

    assign s_lane[0] = q_rdata.s_pitch;
    assign s_lane[1] = q_rdata.s_yaw;

    // Result slot can be refilled when empty or being taken
    assign slot_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (q_rdata.op == OP_REPORT) ? B_REP : B_PP;
                end
            end
            B_PP:    state_next = B_SUM;
            B_SUM:   state_next = B_ACC;
            B_ACC:   state_next = B_IDLE;
            B_REP:
            begin
                if (slot_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            B_IDLE:
            begin
                ctrl.pop     = !q_empty;
                ctrl.load_m  = !q_empty && (q_rdata.op == OP_ACCUM);
                ctrl.load_ip = !q_empty && (q_rdata.op == OP_REPORT);
            end
            B_PP:    ctrl.load_pp   = 1'b1;
            B_SUM:   ctrl.load_incr = 1'b1;
            B_ACC:   ctrl.load_acc  = 1'b1;
            B_REP:   ctrl.load_rep  = slot_free;
            default: ctrl = '0;
        endcase
    end

    assign q_pop = ctrl.pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Per-lane arithmetic
    always_comb
    begin
        logic [LO_W-1:0]          lo;
        logic signed [HI_W-1:0]   hi;
        logic signed [P_W-1:0]    prod;
        logic signed [ACC_W:0]    sum;
        logic signed [IP_W-1:0]   ip_fl;
        logic signed [IP_W-1:0]   ip_tr;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            // sample times microseconds
            m_next[i] = s_lane[i] * $signed({1'b0, q_rdata.us});

            // split product against the gain
            lo            = m_reg[i][LO_W-1:0];
            hi            = m_reg[i][M_W-1:LO_W];
            pp_lo_next[i] = PL_W'(lo) * PL_W'(gain_reg);
            pp_hi_next[i] = hi * $signed({1'b0, gain_reg});

            // recombine and shift with floor rounding
            prod         = (P_W'(pp_hi_reg[i]) <<< LO_W) + $signed(P_W'(pp_lo_reg[i]));
            incr_next[i] = prod[P_W-1:GAIN_SHIFT];

            // saturating accumulate, or subtract the reported integer part
            sum = (ACC_W+1)'(acc_reg[i]) + (ACC_W+1)'(incr_reg[i]);
            if (ctrl.load_rep)
            begin
                acc_next[i] = acc_reg[i] - (ACC_W'(ip_reg[i]) <<< ACC_FRAC_BITS);
            end
            else if (!sum[ACC_W] && sum[ACC_W-1])
            begin
                acc_next[i] = ACC_MAX;
            end
            else if (sum[ACC_W] && !sum[ACC_W-1])
            begin
                acc_next[i] = ACC_MIN;
            end
            else
            begin
                acc_next[i] = sum[ACC_W-1:0];
            end

            // integer part toward zero, clamped
            ip_fl = acc_reg[i][ACC_W-1:ACC_FRAC_BITS];
            ip_tr = ip_fl + IP_W'(acc_reg[i][ACC_W-1] && (|acc_reg[i][ACC_FRAC_BITS-1:0]));
            if (ip_tr > IP_MAX)
            begin
                ip_next[i] = IP_MAX[MOVE_Y_W-1:0];
            end
            else if (ip_tr < IP_MIN)
            begin
                ip_next[i] = IP_MIN[MOVE_Y_W-1:0];
            end
            else
            begin
                ip_next[i] = ip_tr[MOVE_Y_W-1:0];
            end
        end
    end

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.load_m)
        begin
            gain_reg <= q_rdata.gain;
        end
        for (int i = 0; i < NUM_AXES; i++)
        begin
            if (ctrl.load_m)
            begin
                m_reg[i] <= m_next[i];
            end
            if (ctrl.load_pp)
            begin
                pp_lo_reg[i] <= pp_lo_next[i];
                pp_hi_reg[i] <= pp_hi_next[i];
            end
            if (ctrl.load_incr)
            begin
                incr_reg[i] <= incr_next[i];
            end
            if (ctrl.load_ip)
            begin
                ip_reg[i] <= ip_next[i];
            end
        end
    end

    // Accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else if (ctrl.load_acc || ctrl.load_rep)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                acc_reg[i] <= acc_next[i];
            end
        end
    end

    // Result register: load on report, drop after transfer
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (ctrl.load_rep)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_rep)
        begin
            move_x_reg <= -MOVE_X_W'(ip_reg[1]);
            move_y_reg <= ip_reg[0];
        end
    end

    assign out_valid = out_valid_reg;
    assign move_x    = move_x_reg;
    assign move_y    = move_y_reg;

endmodule

/* hw/rtl/rate_integrating_pointer_delta.sv */
// Rate integrating pointer delta: usage notes
// Input channel (in_valid/in_stall) carries gyro samples, joystick samples
// and report ticks; a transfer happens when in_valid is high and in_stall low.
// The front end classifies each item into a two-entry command queue; mode 3
// is taken and dropped. The back end works one command at a time: a sample
// goes through sample times time, split gain multiply, recombine and
// saturating accumulate in turn, a report tick through integer part, then
// subtract and load. A new command is taken only once the last is through.
// A report result passes the queue, the integer part register and the output
// register to reach out_valid. Results move on out_valid/out_stall from the
// output register; while the receiver stalls, the result holds and samples keep
// being integrated; a following report waits until the slot frees up.
// Configuration writes (cfg_valid/cfg_ready, always ready) load the gains and
// stick rest values; the user must see that they are made while the block
// is idle, which the block itself does not enforce. Reset clears both
// accumulators and the queue and restores default gains and rest values.
// Depends on ripd_pkg, ripd_front, ripd_queue and ripd_back.
`timescale 1ns / 1ps

module rate_integrating_pointer_delta
    import ripd_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  mode,
    input  logic [US_W-1:0]             elapsed_us,
    input  logic signed [RATE_W-1:0]    rate_pitch,
    input  logic signed [RATE_W-1:0]    rate_yaw,
    input  logic [ADC_BITS-1:0]         stick_x,
    input  logic [ADC_BITS-1:0]         stick_y,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [MOVE_X_W-1:0]  move_x,
    output logic signed [MOVE_Y_W-1:0]  move_y
);

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_empty;
    q_entry_t q_wdata;
    q_entry_t q_rdata;

    ripd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .elapsed_us (elapsed_us),
        .rate_pitch (rate_pitch),
        .rate_yaw   (rate_yaw),
        .stick_x    (stick_x),
        .stick_y    (stick_y),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_wdata    (q_wdata)
    );

    ripd_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    ripd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_rdata   (q_rdata),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .move_x    (move_x),
        .move_y    (move_y)
    );

endmodule

/* verif/rate_integrating_pointer_delta_tb.sv */
`timescale 1ns / 1ps
// rate_integrating_pointer_delta_tb: self-checking bench for the pointer delta block.
// Predicts each report from its own copy of the accumulators and gains; needs ripd_pkg
// and the rate_integrating_pointer_delta RTL.

module rate_integrating_pointer_delta_tb
    import ripd_pkg::*;
();

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int QUIET_LIMIT    = 2000;
    localparam int MAX_PRINTS     = 40;
    localparam int PHASE_ITEMS    = 50;
    localparam int PRESSURE_ITEMS = 80;
    localparam int SAT_ITEMS      = 20;

    localparam int US_MAX   = (1 << US_W) - 1;
    localparam int RATE_MAX = (1 << (RATE_W - 1)) - 1;
    localparam int RATE_MIN = -(1 << (RATE_W - 1));
    localparam int ADC_MAX  = (1 << ADC_BITS) - 1;
    localparam int WHOLE_MAX = (1 << (MOVE_Y_W - 1)) - 1;
    localparam int WHOLE_MIN = -(1 << (MOVE_Y_W - 1));
    localparam longint ACC_TOP    = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint ACC_BOTTOM = -ACC_TOP - 1;

    typedef struct packed {
        mode_t                      mode;
        logic [US_W-1:0]            us;
        logic signed [RATE_W-1:0]   rate_p;
        logic signed [RATE_W-1:0]   rate_y;
        logic [ADC_BITS-1:0]        stick_x;
        logic [ADC_BITS-1:0]        stick_y;
    } sample_t;

    typedef struct packed {
        logic signed [MOVE_X_W-1:0] x;
        logic signed [MOVE_Y_W-1:0] y;
    } move_t;

    // DUT signals, all inputs known from time zero
    logic                       clk        = 1'b0;
    logic                       rst_n      = 1'b0;
    logic                       cfg_valid  = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index  = '0;
    logic [CFG_DATA_W-1:0]      cfg_data   = '0;
    logic                       in_valid   = 1'b0;
    logic                       in_stall;
    logic [1:0]                 mode       = '0;
    logic [US_W-1:0]            elapsed_us = '0;
    logic signed [RATE_W-1:0]   rate_pitch = '0;
    logic signed [RATE_W-1:0]   rate_yaw   = '0;
    logic [ADC_BITS-1:0]        stick_x    = '0;
    logic [ADC_BITS-1:0]        stick_y    = '0;
    logic                       out_valid;
    logic                       out_stall  = 1'b0;
    logic signed [MOVE_X_W-1:0] move_x;
    logic signed [MOVE_Y_W-1:0] move_y;

    // Pointer model: accumulators and register copies
    longint                     pitch_pos   = 0;
    longint                     yaw_pos     = 0;
    logic [GAIN_W-1:0]          gyro_scale  = GYRO_GAIN_RST;
    logic [GAIN_W-1:0]          stick_scale = JOY_GAIN_RST;
    logic [ADC_BITS-1:0]        rest_x      = JOY_CENTER_X_RST;
    logic [ADC_BITS-1:0]        rest_y      = JOY_CENTER_Y_RST;

    // Traffic bookkeeping
    sample_t                    sample_q[$];
    move_t                      move_exp_q[$];
    sample_t                    cur_sample;
    int                         n_queued      = 0;
    int                         n_taken       = 0;
    int                         mismatches    = 0;
    int unsigned                in_gap_max    = 0;
    int unsigned                out_stall_max = 0;
    int unsigned                gap_left      = 0;
    int unsigned                stall_left    = 0;
    int unsigned                quiet_cycles  = 0;
    logic                       pressure_go   = 1'b0;
    logic                       hold_active   = 1'b0;

    rate_integrating_pointer_delta u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .elapsed_us (elapsed_us),
        .rate_pitch (rate_pitch),
        .rate_yaw   (rate_yaw),
        .stick_x    (stick_x),
        .stick_y    (stick_y),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .move_x     (move_x),
        .move_y     (move_y)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Exact sample * time * gain, floored after dropping the 32 gain fraction bits
    function automatic longint scaled_incr(input longint s, input logic [US_W-1:0] us,
                                           input logic [GAIN_W-1:0] g);
        logic signed [95:0] sw;
        logic signed [95:0] uw;
        logic signed [95:0] gw;
        logic signed [95:0] prod;
        sw = 96'(s);
        uw = {{(96 - US_W){1'b0}}, us};
        gw = {{(96 - GAIN_W){1'b0}}, g};
        prod = sw * uw * gw;
        return longint'(prod >>> GAIN_SHIFT);
    endfunction

    function automatic longint clamp_acc(input longint v);
        if (v > ACC_TOP)
            return ACC_TOP;
        if (v < ACC_BOTTOM)
            return ACC_BOTTOM;
        return v;
    endfunction

    // Whole counts, truncated toward zero and clamped; leave the remainder behind
    function automatic longint take_whole(inout longint acc);
        longint one;
        longint whole;
        one = longint'(1) << ACC_FRAC_BITS;
        whole = acc / one;
        if (whole > WHOLE_MAX)
            whole = WHOLE_MAX;
        if (whole < WHOLE_MIN)
            whole = WHOLE_MIN;
        acc = acc - whole * one;
        return whole;
    endfunction

    // Apply one sample to the accumulators; report ticks yield a move
    function automatic bit advance_pointer(input sample_t s, output move_t mv);
        longint wp;
        longint wy;
        mv = '0;
        case (s.mode)
            MODE_GYRO:
            begin
                pitch_pos = clamp_acc(pitch_pos +
                                      scaled_incr(longint'(s.rate_p), s.us, gyro_scale));
                yaw_pos   = clamp_acc(yaw_pos +
                                      scaled_incr(longint'(s.rate_y), s.us, gyro_scale));
                return 1'b0;
            end
            MODE_JOY:
            begin
                pitch_pos = clamp_acc(pitch_pos + scaled_incr(
                    longint'(s.stick_x) - longint'(rest_x), s.us, stick_scale));
                yaw_pos   = clamp_acc(yaw_pos + scaled_incr(
                    longint'(s.stick_y) - longint'(rest_y), s.us, stick_scale));
                return 1'b0;
            end
            MODE_REPORT:
            begin
                wp = take_whole(pitch_pos);
                wy = take_whole(yaw_pos);
                mv.x = MOVE_X_W'(-wy);
                mv.y = MOVE_Y_W'(wp);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic sample_t make_sample(input mode_t m, input int unsigned us,
                                            input int rp, input int ry,
                                            input int sx, input int sy);
        sample_t s;
        s.mode    = m;
        s.us      = US_W'(us);
        s.rate_p  = RATE_W'(rp);
        s.rate_y  = RATE_W'(ry);
        s.stick_x = ADC_BITS'(sx);
        s.stick_y = ADC_BITS'(sy);
        return s;
    endfunction

    // Mostly realistic intervals, now and then the full 20-bit range
    function automatic sample_t random_sample();
        sample_t s;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            s.mode = MODE_GYRO;
        else if (pick < 65)
            s.mode = MODE_JOY;
        else if (pick < 95)
            s.mode = MODE_REPORT;
        else
            s.mode = MODE_NONE;
        if ($urandom_range(0, 9) == 0)
            s.us = US_W'($urandom);
        else
            s.us = US_W'($urandom_range(0, 4000));
        s.rate_p  = RATE_W'($urandom);
        s.rate_y  = RATE_W'($urandom);
        s.stick_x = ADC_BITS'($urandom);
        s.stick_y = ADC_BITS'($urandom);
        return s;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic queue_sample(input sample_t s);
        sample_q.push_back(s);
        n_queued++;
    endtask

    task automatic queue_random(input int count);
        for (int k = 0; k < count; k++)
            queue_sample(random_sample());
    endtask

    // Wait until every sample is taken and every move seen, then let the back end drain
    task automatic settle_idle();
        do
            @(posedge clk);
        while (!(n_taken == n_queued && move_exp_q.size() == 0));
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all four registers in index order and mirror them in the model
    task automatic program_gains(input logic [31:0] gyro, input logic [31:0] joy,
                                 input logic [31:0] cx, input logic [31:0] cy);
        logic [31:0] vals[4];
        reg_idx_t    idx;
        vals = '{gyro, joy, cx, cy};
        for (int i = 0; i < 4; i++)
        begin
            idx = reg_idx_t'(i);
            @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            case (idx)
                REG_GYRO_GAIN:    gyro_scale  = vals[i];
                REG_JOY_GAIN:     stick_scale = vals[i];
                REG_JOY_CENTER_X: rest_x      = vals[i][ADC_BITS-1:0];
                REG_JOY_CENTER_Y: rest_y      = vals[i][ADC_BITS-1:0];
                default:          ;
            endcase
        end
    endtask

    // Sample driver: predict on each transfer, then offer the next item after its gap
    always @(posedge clk)
    begin : sample_driver
        logic  offering;
        logic  has_move;
        move_t mv;
        offering = in_valid;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                has_move = advance_pointer(cur_sample, mv);
                if (has_move)
                    move_exp_q.push_back(mv);
                n_taken++;
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (sample_q.size() > 0)
                begin
                    cur_sample = sample_q.pop_front();
                    mode       <= cur_sample.mode;
                    elapsed_us <= cur_sample.us;
                    rate_pitch <= cur_sample.rate_p;
                    rate_yaw   <= cur_sample.rate_y;
                    stick_x    <= cur_sample.stick_x;
                    stick_y    <= cur_sample.stick_y;
                    gap_left   = $urandom_range(0, in_gap_max);
                    offering   = 1'b1;
                end
            end
            in_valid <= offering;
        end
    end

    // Move monitor: check each transfer against the oldest prediction, then pick a stall
    always @(posedge clk)
    begin : move_monitor
        move_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (move_exp_q.size() == 0)
                    report_mismatch($sformatf("move %0d,%0d with no report pending",
                                              move_x, move_y));
                else
                begin
                    want = move_exp_q.pop_front();
                    if (move_x !== want.x)
                        report_mismatch($sformatf("move_x got %0d want %0d",
                                                  move_x, want.x));
                    if (move_y !== want.y)
                        report_mismatch($sformatf("move_y got %0d want %0d",
                                                  move_y, want.y));
                end
                stall_left = $urandom_range(0, out_stall_max);
            end
            else if (out_valid && stall_left > 0)
            begin
                stall_left--;
            end
            out_stall <= hold_active || (stall_left > 0);
        end
    end

    // Long receiver hold-off so that reports back up and the input stalls
    initial
    begin : pressure_hold
        wait (pressure_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    // Abort when no transfer of any kind happens for too long
    always @(posedge clk)
    begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : test_sequence
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Reset gains: directed corners first
        in_gap_max    = 10;
        out_stall_max = 10;
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        queue_sample(make_sample(MODE_GYRO, 40000, RATE_MAX, RATE_MIN, 0, 0));
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        queue_sample(make_sample(MODE_GYRO, 0, RATE_MAX, RATE_MIN, ADC_MAX, ADC_MAX));
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        // tiny negative step floors to minus one; whole part truncates to zero
        queue_sample(make_sample(MODE_GYRO, 1, -1, 1, 0, 0));
        queue_sample(make_sample(MODE_REPORT, US_MAX, RATE_MIN, RATE_MAX, ADC_MAX, 0));
        queue_sample(make_sample(MODE_JOY, 20000, 0, 0, 0, ADC_MAX));
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        queue_sample(make_sample(MODE_JOY, US_MAX, 0, 0, JOY_CENTER_X_RST, JOY_CENTER_Y_RST));
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        queue_sample(make_sample(MODE_JOY, US_MAX, RATE_MAX, RATE_MIN, ADC_MAX, 0));
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        // unused mode: dropped without a move
        queue_sample(make_sample(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom));
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        queue_sample(make_sample(MODE_GYRO, US_MAX, RATE_MIN, RATE_MAX, 0, 0));
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        queue_random(PHASE_ITEMS);
        settle_idle();

        // Extreme gains and rest values, no idling
        program_gains(32'd0, 32'hFFFF_FFFF, 32'd0, 32'(ADC_MAX));
        in_gap_max    = 0;
        out_stall_max = 0;
        queue_random(PHASE_ITEMS);
        settle_idle();

        // Opposite extremes, sender gaps only
        program_gains(32'hFFFF_FFFF, 32'd0, 32'(ADC_MAX), 32'd0);
        in_gap_max    = 10;
        out_stall_max = 0;
        queue_random(PHASE_ITEMS);
        settle_idle();

        // Random registers, receiver stalls only
        program_gains($urandom, $urandom, $urandom, $urandom);
        in_gap_max    = 0;
        out_stall_max = 10;
        queue_random(PHASE_ITEMS);
        settle_idle();

        // Reset values back; hold the receiver while the sender keeps offering
        program_gains(GYRO_GAIN_RST, JOY_GAIN_RST, 32'(JOY_CENTER_X_RST),
                      32'(JOY_CENTER_Y_RST));
        in_gap_max    = 0;
        out_stall_max = 4;
        pressure_go   = 1'b1;
        queue_random(PRESSURE_ITEMS);
        settle_idle();

        program_gains($urandom, $urandom, $urandom, $urandom);
        in_gap_max    = 10;
        out_stall_max = 10;
        queue_random(PHASE_ITEMS);
        settle_idle();

        // Full-scale steps in one direction, then a longer run the other way
        program_gains(32'hFFFF_FFFF, $urandom, $urandom, $urandom);
        in_gap_max    = 0;
        out_stall_max = 2;
        for (int k = 0; k < SAT_ITEMS; k++)
            queue_sample(make_sample(MODE_GYRO, US_MAX, RATE_MAX, RATE_MIN, 0, 0));
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        queue_sample(make_sample(MODE_GYRO, US_MAX, RATE_MAX, RATE_MIN, 0, 0));
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        for (int k = 0; k < 2 * SAT_ITEMS; k++)
            queue_sample(make_sample(MODE_GYRO, US_MAX, RATE_MIN, RATE_MAX, 0, 0));
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        queue_sample(make_sample(MODE_GYRO, US_MAX, RATE_MIN, RATE_MAX, 0, 0));
        queue_sample(make_sample(MODE_REPORT, 0, 0, 0, 0, 0));
        settle_idle();

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
